// File: design/kps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types and constants of the keyword presence scorer: command codes,
// the input and result beat layouts and the script characters.
// ----------------------------------------------------------------------------
package kps_pkg;

    typedef enum logic [2:0] {
        CMD_SCRIPT_BYTE = 3'd0,
        CMD_END_SCRIPT  = 3'd1,
        CMD_TEXT_BYTE   = 3'd2,
        CMD_REPORT      = 3'd3,
        CMD_CLEAR_ALL   = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] script_byte;
        logic [7:0] text_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] found_mask;
        logic [3:0] found_count;
        logic [3:0] keyword_count;
        logic       too_many_keywords;
        logic       keyword_too_long;
    } out_beat_t;

    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_DELTA   = 8'h20;

endpackage

// File: design/kps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kps_if
// Valid/ready channels of the keyword presence scorer: one for command beats
// in, one for report beats out.
// ----------------------------------------------------------------------------
interface kps_in_if
    import kps_pkg::*;
;
    logic     valid;
    logic     ready;
    in_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface kps_out_if
    import kps_pkg::*;
;
    logic      valid;
    logic      ready;
    out_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/keyword_presence_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_presence_scorer
// Case-insensitive presence check of up to MAX_KEYWORDS keywords, loaded from
// a comma-separated script, against a streamed text.
// ----------------------------------------------------------------------------
// Usage:
//   req carries command beats: script bytes, end of script, text bytes,
//   report and clear all. rsp carries one beat per report: found mask, found
//   count, keyword count and the two overflow flags.
//   Each accepted beat lands in an input register and is executed from there
//   against the keyword store and the text window; a report result is written
//   to the output register when the report executes, so rsp.valid rises from
//   the result register after the report leaves the input register.
//   Throughput is one beat per cycle for every command unless a report waits
//   for rsp; the window compare of all slots is one pass of parallel byte compares.
//   When rsp stalls, the pending report holds rsp; one more beat is held in
//   the input register, and text or script beats keep executing. Only a second
//   report waits until the first result is taken, and then req.ready drops.
//   Reset (and the clear-all command) empties the keyword list, the window,
//   the found flags and the overflow flags; stored keyword bytes are not
//   cleared, they are only read after being rewritten.
//   A report clears the window and the found flags but keeps the keywords.
// ----------------------------------------------------------------------------
module keyword_presence_scorer
    import kps_pkg::*;
#(
    parameter int MAX_KEYWORDS    = 8,
    parameter int MAX_KEYWORD_LEN = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    kps_in_if.sink          req,
    kps_out_if.source       rsp
);

    // count of slots 0..MAX_KEYWORDS
    localparam int KCW = $clog2(MAX_KEYWORDS + 1);
    // keyword length 0..MAX_KEYWORD_LEN
    localparam int LW  = $clog2(MAX_KEYWORD_LEN + 1);
    // token position runs one past the length limit
    localparam int TPW = $clog2(MAX_KEYWORD_LEN + 2);
    // index into the window / a keyword row
    localparam int PIW = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};
    endfunction

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic     s1_valid_reg;
    logic     s1_valid_next;
    in_beat_t s1_beat_reg;
    cmd_t     s1_cmd;
    logic     s1_go;
    logic     in_fire;

    // ------------------------------------------------------------------
    // Block state
    // ------------------------------------------------------------------
    logic [7:0]              store_reg [MAX_KEYWORDS][MAX_KEYWORD_LEN];
    logic [LW-1:0]           len_reg   [MAX_KEYWORDS];
    logic [LW-1:0]           len_next  [MAX_KEYWORDS];
    logic [KCW-1:0]          total_reg;
    logic [KCW-1:0]          total_next;
    logic [TPW-1:0]          pos_reg;
    logic [TPW-1:0]          pos_next;
    logic [TPW-1:0]          trim_reg;
    logic [TPW-1:0]          trim_next;
    logic [7:0]              win_reg   [MAX_KEYWORD_LEN];
    logic [7:0]              win_new   [MAX_KEYWORD_LEN];
    logic                    win_shift;
    logic [LW-1:0]           fill_reg;
    logic [LW-1:0]           fill_next;
    logic [LW-1:0]           fill_new;
    logic [MAX_KEYWORDS-1:0] flags_reg;
    logic [MAX_KEYWORDS-1:0] flags_next;
    logic                    too_many_reg;
    logic                    too_many_next;
    logic                    too_long_reg;
    logic                    too_long_next;

    // store write port
    logic                    st_we;
    logic [KCW-1:0]          st_slot;
    logic [TPW-1:0]          st_pos;
    logic [7:0]              st_data;

    // per-slot compare
    logic [MAX_KEYWORDS-1:0] occ_mask;
    logic [MAX_KEYWORDS-1:0] hit_vec;
    logic [KCW-1:0]          found_cnt;

    // result register
    logic                    rsp_valid_reg;
    logic                    rsp_valid_next;
    out_beat_t               rsp_payload_reg;
    out_beat_t               rsp_payload_next;

    logic [7:0]              script_lc;
    logic                    script_blank;
    logic                    close_keep;
    logic                    close_full;
    logic                    close_long;

    // a report may only execute once the result register is free
    assign s1_cmd  = cmd_t'(s1_beat_reg.command);
    assign s1_go   = s1_valid_reg &&
                     !(s1_cmd == CMD_REPORT && rsp_valid_reg && !rsp.ready);
    assign req.ready = !s1_valid_reg || s1_go;
    assign in_fire   = req.valid && req.ready;

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    always_comb
    begin
        s1_valid_next = in_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
    end

    // ------------------------------------------------------------------
    // Window compare: newest byte at index 0, keyword byte i against
    // window byte len-1-i, for every slot in parallel
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [LW-1:0] diff;
        logic          ok;
        diff = '0;
        ok   = 1'b0;

        win_new[0] = to_lower(s1_beat_reg.text_byte);
        for (int j = 1; j < MAX_KEYWORD_LEN; j++)
        begin
            win_new[j] = win_reg[j-1];
        end
        fill_new = (fill_reg < LW'(MAX_KEYWORD_LEN)) ? fill_reg + LW'(1) : fill_reg;

        for (int k = 0; k < MAX_KEYWORDS; k++)
        begin
            occ_mask[k] = KCW'(k) < total_reg;
            ok = occ_mask[k] && (len_reg[k] != '0) && (len_reg[k] <= fill_new);
            for (int i = 0; i < MAX_KEYWORD_LEN; i++)
            begin
                diff = len_reg[k] - LW'(1) - LW'(i);
                if (LW'(i) < len_reg[k] && win_new[diff[PIW-1:0]] != store_reg[k][i])
                begin
                    ok = 1'b0;
                end
            end
            hit_vec[k] = ok;
        end

        found_cnt = '0;
        for (int k = 0; k < MAX_KEYWORDS; k++)
        begin
            found_cnt = found_cnt + KCW'(flags_reg[k]);
        end
    end

    // ------------------------------------------------------------------
    // Execute the beat held in the input register
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [MAX_KEYWORDS+7:0] mask_wide;
        logic [KCW+3:0]          cnt_wide;
        logic [KCW+3:0]          total_wide;
        mask_wide  = {8'b0, flags_reg};
        cnt_wide   = {4'b0, found_cnt};
        total_wide = {4'b0, total_reg};

        script_lc    = to_lower(s1_beat_reg.script_byte);
        script_blank = is_blank(s1_beat_reg.script_byte);

        // closing the pending token
        close_keep = trim_reg != '0;
        close_full = total_reg >= KCW'(MAX_KEYWORDS);
        close_long = trim_reg > TPW'(MAX_KEYWORD_LEN);

        for (int k = 0; k < MAX_KEYWORDS; k++)
        begin
            len_next[k] = len_reg[k];
        end
        total_next      = total_reg;
        pos_next        = pos_reg;
        trim_next       = trim_reg;
        fill_next       = fill_reg;
        flags_next      = flags_reg;
        too_many_next   = too_many_reg;
        too_long_next   = too_long_reg;
        win_shift       = 1'b0;
        st_we           = 1'b0;
        st_slot         = total_reg;
        st_pos          = pos_reg;
        st_data         = script_lc;
        rsp_valid_next  = rsp.ready ? 1'b0 : rsp_valid_reg;

        rsp_payload_next.found_mask        = mask_wide[7:0];
        rsp_payload_next.found_count       = cnt_wide[3:0];
        rsp_payload_next.keyword_count     = total_wide[3:0];
        rsp_payload_next.too_many_keywords = too_many_reg;
        rsp_payload_next.keyword_too_long  = too_long_reg;

        if (s1_go)
        begin
            case (s1_cmd)
                CMD_SCRIPT_BYTE, CMD_END_SCRIPT:
                begin
                    if (s1_cmd == CMD_END_SCRIPT || s1_beat_reg.script_byte == CHAR_COMMA)
                    begin
                        if (close_keep)
                        begin
                            if (close_long)
                            begin
                                too_long_next = 1'b1;
                            end
                            if (close_full)
                            begin
                                too_many_next = 1'b1;
                            end
                            else
                            begin
                                for (int k = 0; k < MAX_KEYWORDS; k++)
                                begin
                                    if (KCW'(k) == total_reg)
                                    begin
                                        len_next[k] = close_long ? '0 : trim_reg[LW-1:0];
                                    end
                                end
                                total_next = total_reg + KCW'(1);
                            end
                        end
                        pos_next  = '0;
                        trim_next = '0;
                    end
                    else if (!(script_blank && pos_reg == '0))
                    begin
                        st_we = (pos_reg < TPW'(MAX_KEYWORD_LEN)) && !close_full;
                        if (pos_reg <= TPW'(MAX_KEYWORD_LEN))
                        begin
                            pos_next = pos_reg + TPW'(1);
                        end
                        if (!script_blank)
                        begin
                            trim_next = pos_next;
                        end
                    end
                end
                CMD_TEXT_BYTE:
                begin
                    win_shift  = 1'b1;
                    fill_next  = fill_new;
                    flags_next = flags_reg | hit_vec;
                end
                CMD_REPORT:
                begin
                    rsp_valid_next = 1'b1;
                    fill_next      = '0;
                    flags_next     = '0;
                end
                CMD_CLEAR_ALL:
                begin
                    for (int k = 0; k < MAX_KEYWORDS; k++)
                    begin
                        len_next[k] = '0;
                    end
                    total_next    = '0;
                    pos_next      = '0;
                    trim_next     = '0;
                    fill_next     = '0;
                    flags_next    = '0;
                    too_many_next = 1'b0;
                    too_long_next = 1'b0;
                end
                default:
                begin
                    // unused command codes: drop the beat
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            for (int k = 0; k < MAX_KEYWORDS; k++)
            begin
                len_reg[k] <= '0;
            end
            total_reg     <= '0;
            pos_reg       <= '0;
            trim_reg      <= '0;
            fill_reg      <= '0;
            flags_reg     <= '0;
            too_many_reg  <= 1'b0;
            too_long_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            for (int k = 0; k < MAX_KEYWORDS; k++)
            begin
                len_reg[k] <= len_next[k];
            end
            total_reg     <= total_next;
            pos_reg       <= pos_next;
            trim_reg      <= trim_next;
            fill_reg      <= fill_next;
            flags_reg     <= flags_next;
            too_many_reg  <= too_many_next;
            too_long_reg  <= too_long_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: input beat, result, window and keyword bytes
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_beat_reg <= req.payload;
        end
        if (s1_go && s1_cmd == CMD_REPORT)
        begin
            rsp_payload_reg <= rsp_payload_next;
        end
        if (win_shift)
        begin
            for (int j = 0; j < MAX_KEYWORD_LEN; j++)
            begin
                win_reg[j] <= win_new[j];
            end
        end
        for (int k = 0; k < MAX_KEYWORDS; k++)
        begin
            for (int i = 0; i < MAX_KEYWORD_LEN; i++)
            begin
                if (st_we && st_slot == KCW'(k) && st_pos == TPW'(i))
                begin
                    store_reg[k][i] <= st_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTH
    a_report_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_cmd == CMD_REPORT) |=> rsp_valid_reg)
        else $error("executed report did not load the result register");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= KCW'(MAX_KEYWORDS))
        else $error("keyword count beyond slot count");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= LW'(MAX_KEYWORD_LEN))
        else $error("window fill beyond window length");

    a_flags_in_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (flags_reg & ~occ_mask) == '0)
        else $error("found flag set for an empty slot");

    a_trim_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        trim_reg <= pos_reg)
        else $error("trimmed token length beyond token position");
`endif

endmodule
